// ===== src/tcw_pkg.sv =====
// shared types, codes and constants of the text console writer
package tcw_pkg;

    // default geometry
    localparam int DEF_COLUMNS  = 80;
    localparam int DEF_ROWS     = 25;
    localparam int DEF_TAB_STEP = 4;

    // request queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // address field of a queue entry, wide enough for the largest geometry
    localparam int ENTRY_ADDR_W = 13;

    // command codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // control characters
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_RETURN  = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;

    // colour registers
    localparam logic       REG_FOREGROUND = 1'b0;
    localparam logic       REG_BACKGROUND = 1'b1;
    localparam logic [3:0] RESET_FG       = 4'h0;
    localparam logic [3:0] RESET_BG       = 4'hF;

    // blank cell in the reset colour
    localparam logic [15:0] RESET_BLANK = {RESET_BG, RESET_FG, CH_SPACE};

    typedef enum logic [2:0] {
        OP_PUT,
        OP_NEWLINE,
        OP_RETURN,
        OP_TAB,
        OP_CLEAR,
        OP_READ,
        OP_NOP
    } t_op;

    typedef struct packed {
        t_op                     op;
        logic [7:0]              char_code;
        logic                    rd_ok;
        logic [ENTRY_ADDR_W-1:0] rd_addr;
    } t_entry;

    typedef struct packed {
        logic init_busy;
    } t_back_status;

endpackage

// ===== src/tcw_ifs.sv =====
// request and result channel interfaces of the text console writer
interface text_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] char_code;
    logic [4:0] read_row;
    logic [6:0] read_col;

    modport source (output valid, command, char_code, read_row, read_col, input ready);
    modport sink (input valid, command, char_code, read_row, read_col, output ready);
endinterface

interface text_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;

    modport source (output valid, cell_value, cursor_row, cursor_col, input ready);
    modport sink (input valid, cell_value, cursor_row, cursor_col, output ready);
endinterface

// ===== src/tcw_front.sv =====
// front end: accepts requests and decodes them into queue entries
module tcw_front #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    text_in_if.sink              i_req,
    input  tcw_pkg::t_back_status i_status,
    input  logic                  i_full,
    output logic                  o_push,
    output tcw_pkg::t_entry       o_entry
);

    tcw_pkg::t_entry entry;

    assign i_req.ready = !i_full && !i_status.init_busy;
    assign o_push      = i_req.valid && i_req.ready;
    assign o_entry     = entry;

    always_comb begin
        entry.char_code = i_req.char_code;
        entry.rd_ok     = (int'(i_req.read_row) < ROWS) && (int'(i_req.read_col) < COLUMNS);
        entry.rd_addr   = tcw_pkg::ENTRY_ADDR_W'(int'(i_req.read_row) * COLUMNS
                                                 + int'(i_req.read_col));
        case (i_req.command)
            tcw_pkg::CMD_PUT: begin
                case (i_req.char_code)
                    tcw_pkg::CH_NEWLINE: entry.op = tcw_pkg::OP_NEWLINE;
                    tcw_pkg::CH_RETURN:  entry.op = tcw_pkg::OP_RETURN;
                    tcw_pkg::CH_TAB:     entry.op = tcw_pkg::OP_TAB;
                    default:             entry.op = tcw_pkg::OP_PUT;
                endcase
            end
            tcw_pkg::CMD_CLEAR: entry.op = tcw_pkg::OP_CLEAR;
            tcw_pkg::CMD_READ:  entry.op = tcw_pkg::OP_READ;
            default:            entry.op = tcw_pkg::OP_NOP;
        endcase
    end

endmodule

// ===== src/tcw_fifo.sv =====
// short request queue between the front end and the cell engine
module tcw_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  tcw_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_valid,
    output tcw_pkg::t_entry o_entry
);

    localparam int DEPTH = tcw_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcw_pkg::t_entry r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_slot[r_wr_ptr] <= i_entry;
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// ===== src/tcw_back.sv =====
// cell engine: cursor, cell store, scroll and clear sweeps, result register
module tcw_back #(
    parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS     = tcw_pkg::DEF_ROWS,
    parameter int TAB_STEP = tcw_pkg::DEF_TAB_STEP
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  tcw_pkg::t_entry       i_q_entry,
    input  logic [7:0]            i_colour,
    output logic                  o_q_pop,
    output tcw_pkg::t_back_status o_status,
    text_out_if.source            o_rsp
);

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int COPY_N = COLUMNS * (ROWS - 1);
    localparam int ADDR_W = $clog2(CELLS);
    localparam int CW     = $clog2(COLUMNS + TAB_STEP);
    localparam int RW     = $clog2(ROWS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    logic [15:0] r_mem [CELLS];

    t_state            r_state;
    logic [RW-1:0]     r_row;
    logic [CW-1:0]     r_col;
    logic [ADDR_W-1:0] r_idx;
    logic              r_copy;
    logic              r_give;
    logic [15:0]       r_blank;
    logic              r_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr;
    logic              r_wr_blank;
    logic              r_init_busy;
    logic [15:0]       r_rd_data;
    logic              r_out_valid;
    logic [15:0]       r_out_cell;
    logic [RW-1:0]     r_out_row;
    logic [CW-1:0]     r_out_col;

    tcw_pkg::t_entry   e;
    logic              pop;
    logic [CW-1:0]     n_col;
    logic [RW-1:0]     n_row;
    logic              scroll;
    logic              wr_char;
    logic              we;
    logic [ADDR_W-1:0] wr_addr;
    logic [15:0]       wr_data;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] cur_addr;

    assign e        = i_q_entry;
    assign pop      = (r_state == ST_IDLE) && i_q_valid && (!r_out_valid || o_rsp.ready);
    assign o_q_pop  = pop;
    assign o_status.init_busy = r_init_busy;

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.cell_value = r_out_cell;
    assign o_rsp.cursor_row = 5'(r_out_row);
    assign o_rsp.cursor_col = 7'(r_out_col);

    assign cur_addr = ADDR_W'(int'(r_row) * COLUMNS + int'(r_col));

    // cursor step for one put request
    always_comb begin
        n_col   = r_col;
        n_row   = r_row;
        wr_char = 1'b0;
        case (e.op)
            tcw_pkg::OP_PUT: begin
                n_col   = r_col + CW'(1);
                wr_char = 1'b1;
            end
            tcw_pkg::OP_NEWLINE: begin
                n_col = '0;
                n_row = r_row + RW'(1);
            end
            tcw_pkg::OP_RETURN: n_col = '0;
            tcw_pkg::OP_TAB:    n_col = r_col + CW'(TAB_STEP);
            default: ;
        endcase
        if (n_col >= CW'(COLUMNS)) begin
            n_col = '0;
            n_row = n_row + RW'(1);
        end
        scroll = (n_row >= RW'(ROWS));
        if (scroll) begin
            n_row = RW'(ROWS - 1);
        end
    end

    // single write port: sweep writes or a character write
    always_comb begin
        we      = r_wr_pend || (pop && wr_char);
        wr_addr = r_wr_pend ? r_wr_addr : cur_addr;
        if (r_wr_pend) begin
            wr_data = r_wr_blank ? r_blank : r_rd_data;
        end else begin
            wr_data = {i_colour, e.char_code};
        end
        if (r_state == ST_SWEEP) begin
            rd_addr = ADDR_W'(int'(r_idx) + COLUMNS);
        end else begin
            rd_addr = ADDR_W'(e.rd_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_SWEEP;
            r_row       <= '0;
            r_col       <= '0;
            r_idx       <= '0;
            r_copy      <= 1'b0;
            r_give      <= 1'b0;
            r_blank     <= tcw_pkg::RESET_BLANK;
            r_wr_pend   <= 1'b0;
            r_init_busy <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_wr_pend <= 1'b0;
            if (r_out_valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (pop) begin
                        case (e.op)
                            tcw_pkg::OP_PUT, tcw_pkg::OP_NEWLINE,
                            tcw_pkg::OP_RETURN, tcw_pkg::OP_TAB: begin
                                r_row <= n_row;
                                r_col <= n_col;
                                if (scroll) begin
                                    r_state <= ST_SWEEP;
                                    r_idx   <= '0;
                                    r_copy  <= 1'b1;
                                    r_give  <= 1'b1;
                                    r_blank <= {i_colour, tcw_pkg::CH_SPACE};
                                end else begin
                                    r_out_valid <= 1'b1;
                                    r_out_cell  <= '0;
                                    r_out_row   <= n_row;
                                    r_out_col   <= n_col;
                                end
                            end
                            tcw_pkg::OP_CLEAR: begin
                                r_row   <= '0;
                                r_col   <= '0;
                                r_state <= ST_SWEEP;
                                r_idx   <= '0;
                                r_copy  <= 1'b0;
                                r_give  <= 1'b1;
                                r_blank <= {i_colour, tcw_pkg::CH_SPACE};
                            end
                            tcw_pkg::OP_READ: begin
                                if (e.rd_ok) begin
                                    r_state <= ST_READ;
                                end else begin
                                    r_out_valid <= 1'b1;
                                    r_out_cell  <= '0;
                                    r_out_row   <= r_row;
                                    r_out_col   <= r_col;
                                end
                            end
                            default: begin
                                r_out_valid <= 1'b1;
                                r_out_cell  <= '0;
                                r_out_row   <= r_row;
                                r_out_col   <= r_col;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    r_out_valid <= 1'b1;
                    r_out_cell  <= r_rd_data;
                    r_out_row   <= r_row;
                    r_out_col   <= r_col;
                    r_state     <= ST_IDLE;
                end
                ST_SWEEP: begin
                    // read runs one row ahead, the write lands in the next cycle
                    r_wr_pend  <= 1'b1;
                    r_wr_addr  <= r_idx;
                    r_wr_blank <= !r_copy || (r_idx >= ADDR_W'(COPY_N));
                    r_idx      <= r_idx + ADDR_W'(1);
                    if (r_idx == ADDR_W'(CELLS - 1)) begin
                        r_state <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (r_give) begin
                        r_out_valid <= 1'b1;
                        r_out_cell  <= '0;
                        r_out_row   <= r_row;
                        r_out_col   <= r_col;
                    end
                    r_init_busy <= 1'b0;
                    r_state     <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== src/text_console_writer.sv =====
// top level of the text console writer
//
//  channel   dir  handshake            payload
//  i_req     in   valid / ready        command, char_code, read_row, read_col
//  o_rsp     out  valid / ready        cell_value, cursor_row, cursor_col
//  i_cfg_*   in   write enable only    index (0 foreground, 1 background), data
//
// a printable character, return, tab, newline without scroll, an unknown
// command or an out-of-range read is answered straight from the idle state; a
// read inside the store passes through a read state (registered memory read)
// a scroll or clear walks the cell store once, one cell per cycle, copy reads
// running one row ahead of the writes
// after reset the store is blanked in the reset colour, with i_req.ready low;
// colour writes still land
// a two-entry queue lets requests come in while the engine sweeps or while a
// result waits on o_rsp.ready; the engine only takes a request when the
// result register is free or being drained
module text_console_writer #(
    parameter int COLUMNS  = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS     = tcw_pkg::DEF_ROWS,
    parameter int TAB_STEP = tcw_pkg::DEF_TAB_STEP
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    text_in_if.sink    i_req,
    text_out_if.source o_rsp,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    // colour registers, background nibble over foreground nibble
    logic [3:0] r_fg;
    logic [3:0] r_bg;

    // front to queue
    logic            push;
    tcw_pkg::t_entry push_entry;
    logic            q_full;

    // queue to engine
    logic            q_valid;
    logic            q_pop;
    tcw_pkg::t_entry q_entry;

    // engine status back to the front (reset blanking in progress)
    tcw_pkg::t_back_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= tcw_pkg::RESET_FG;
            r_bg <= tcw_pkg::RESET_BG;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tcw_pkg::REG_FOREGROUND: r_fg <= i_cfg_data;
                tcw_pkg::REG_BACKGROUND: r_bg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // decode requests, hold off while the store is being blanked
    tcw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .i_req    (i_req),
        .i_status (status),
        .i_full   (q_full),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    // decoupling queue
    tcw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (q_entry)
    );

    // cursor, cell store and result register
    tcw_back #(
        .COLUMNS  (COLUMNS),
        .ROWS     (ROWS),
        .TAB_STEP (TAB_STEP)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_entry (q_entry),
        .i_colour  ({r_bg, r_fg}),
        .o_q_pop   (q_pop),
        .o_status  (status),
        .o_rsp     (o_rsp)
    );

endmodule

// ===== src/tcw_checker.sv =====
// port-level checks of the text console writer and their binding
module tcw_checker #(
    parameter int COLUMNS = tcw_pkg::DEF_COLUMNS,
    parameter int ROWS    = tcw_pkg::DEF_ROWS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_cell_value,
    input logic [4:0]  i_cursor_row,
    input logic [6:0]  i_cursor_col
);

    // store blanking right after reset keeps requests out
    a_ready_low_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_in_ready)
        else $error("request taken during reset blanking");

    // no result right after reset
    a_no_result_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result shown right after reset");

    // reported cursor stays inside the screen
    a_cursor_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_cursor_col) < COLUMNS))
        else $error("cursor column out of range");

    a_cursor_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (int'(i_cursor_row) < ROWS))
        else $error("cursor row out of range");

    // a stalled result holds
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_cell_value)
            && $stable(i_cursor_row) && $stable(i_cursor_col)))
        else $error("stalled result changed");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_cell_value (o_rsp.cell_value),
    .i_cursor_row (o_rsp.cursor_row),
    .i_cursor_col (o_rsp.cursor_col)
);
